### rtl/mme_pkg.sv
// Shared types, constants and a helper function of the matrix multiply engine.
// Used by every module of the block but mme_ram; depends on nothing else.

package mme_pkg;

	localparam int DEF_MAX_DIM = 8;

	localparam int DIM_W   = 4;
	localparam int IDX_W   = 3;
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 2 * ELEM_W;
	localparam int VALUE_W = 35;
	localparam int CMD_W   = 2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

	localparam logic [1:0] REG_ROWS_OF_A  = 2'd0;
	localparam logic [1:0] REG_SHARED_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_OF_B  = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [ELEM_W-1:0] value;
	} mme_item_t;

	typedef struct packed {
		logic [DIM_W-1:0] m;
		logic [DIM_W-1:0] n;
		logic [DIM_W-1:0] p;
	} mme_dims_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input int unsigned max_dim);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > max_dim) begin
			r = DIM_W'(max_dim);
		end
		return r;
	endfunction

endpackage

### rtl/mme_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the operand stores of the matrix multiply engine.

module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/mme_front.sv
// Front end: accepts input words, drops loads outside the sizes and unused
// commands, and holds the rest in a short queue. Depends on mme_pkg.

module mme_front import mme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  mme_item_t in_item,
	input  mme_dims_t dims,
	output logic      q_valid,
	output mme_item_t q_item,
	input  logic      q_pop
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	mme_item_t        queue_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             keep;
	logic             push;

	always_comb begin
		case (in_item.cmd)
			CMD_LOAD_A: keep = ({1'b0, in_item.row} < dims.m) && ({1'b0, in_item.col} < dims.n);
			CMD_LOAD_B: keep = ({1'b0, in_item.row} < dims.n) && ({1'b0, in_item.col} < dims.p);
			CMD_START:  keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	assign in_ready = (count_q != CNT_W'(QDEPTH));
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = (count_q != '0);
	assign q_item   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != '0)
		else $error("queue popped while empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("queue fill count beyond its depth");

endmodule

### rtl/mme_back.sv
// Back end: writes loads into the operand stores and walks the product with
// one multiply-accumulate unit. Depends on mme_pkg and mme_ram.

module mme_back import mme_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mme_dims_t                 dims,
	input  logic                      q_valid,
	input  mme_item_t                 q_item,
	output logic                      q_pop,
	output logic [IDX_W-1:0]          out_row,
	output logic [IDX_W-1:0]          out_col,
	output logic signed [VALUE_W-1:0] out_value,
	output logic                      last,
	output logic                      out_valid,
	input  logic                      out_ready
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LAUNCH = 2'd1;
	localparam logic [1:0] ST_ISSUE  = 2'd2;
	localparam logic [1:0] ST_WAIT   = 2'd3;

	logic [1:0]       state_q;
	logic [DIM_W-1:0] i_q;
	logic [DIM_W-1:0] j_q;
	logic [DIM_W-1:0] k_q;

	logic              a_we;
	logic              b_we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     a_raddr;
	logic [AW-1:0]     b_raddr;
	logic [ELEM_W-1:0] a_rdata;
	logic [ELEM_W-1:0] b_rdata;

	logic issue;
	logic k_last;
	logic i_last;
	logic j_last;
	logic pipe_busy;

	logic             v_s1;
	logic             first_s1;
	logic             lastk_s1;
	logic             lastel_s1;
	logic [IDX_W-1:0] row_s1;
	logic [IDX_W-1:0] col_s1;

	logic                     v_s2;
	logic                     first_s2;
	logic                     lastk_s2;
	logic                     lastel_s2;
	logic [IDX_W-1:0]         row_s2;
	logic [IDX_W-1:0]         col_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [VALUE_W-1:0] acc_q;
	logic signed [VALUE_W-1:0] acc_next;
	logic                      out_valid_q;

	assign q_pop = q_valid && (state_q == ST_IDLE);
	assign a_we  = q_pop && (q_item.cmd == CMD_LOAD_A);
	assign b_we  = q_pop && (q_item.cmd == CMD_LOAD_B);
	assign waddr = AW'(32'(q_item.row) * MAX_DIM + 32'(q_item.col));

	assign a_raddr = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign b_raddr = AW'(32'(k_q) * MAX_DIM + 32'(j_q));

	assign issue     = (state_q == ST_ISSUE);
	assign k_last    = (k_q == dims.n - 1'b1);
	assign i_last    = (i_q == dims.m - 1'b1);
	assign j_last    = (j_q == dims.p - 1'b1);
	assign pipe_busy = v_s1 || v_s2;

	mme_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(DEPTH)
	) u_a_store (
		.clk  (clk),
		.we   (a_we),
		.waddr(waddr),
		.wdata(q_item.value),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	mme_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(DEPTH)
	) u_b_store (
		.clk  (clk),
		.we   (b_we),
		.waddr(waddr),
		.wdata(q_item.value),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_item.cmd == CMD_START) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					if (!out_valid_q || out_ready) begin
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					k_q <= k_q + 1'b1;
					if (k_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!pipe_busy) begin
						if (i_last && j_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_last) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= ST_LAUNCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2 && lastk_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign acc_next = (first_s2 ? '0 : acc_q) + VALUE_W'(prod_s2);

	always_ff @(posedge clk) begin
		first_s1  <= (k_q == '0);
		lastk_s1  <= k_last;
		lastel_s1 <= i_last && j_last;
		row_s1    <= i_q[IDX_W-1:0];
		col_s1    <= j_q[IDX_W-1:0];

		first_s2  <= first_s1;
		lastk_s2  <= lastk_s1;
		lastel_s2 <= lastel_s1;
		row_s2    <= row_s1;
		col_s2    <= col_s1;
		prod_s2   <= $signed(a_rdata) * $signed(b_rdata);

		if (v_s2) begin
			acc_q <= acc_next;
		end
		if (v_s2 && lastk_s2) begin
			out_value <= acc_next;
			out_row   <= row_s2;
			out_col   <= col_s2;
			last      <= lastel_s2;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && lastk_s2 |-> !out_valid_q)
		else $error("result overwrote a word still waiting at the output");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !first_s2 |-> $past(v_s2))
		else $error("accumulation continued without a preceding product");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pipe_busy)
		else $error("operand stores open to loads while products are in flight");

endmodule

### rtl/matrix_multiply_engine_top.sv
// Top level of the matrix multiply engine: size registers on the APB-style
// port and the front and back ends. Depends on mme_pkg, mme_front, mme_back.
//
// Input channel (in_valid/in_ready): each word is a load of one element of A
// or B, or a start. Loads outside the configured sizes and the unused command
// are taken and dropped. Loads are taken one a cycle while the queue has
// room, and are written once any walk ahead of them has ended. A start makes
// the block send every element of C = A x B in row-major order on the output
// channel (out_valid/out_ready), with last high on the final element.
// While out_ready stays high, each result element passes through launch, one
// term a cycle in one multiply-accumulate unit fed by the two store read
// ports, registered read, product and drain.
// Words behind a start wait in a two-word queue, so the input stalls once
// that queue is full until the walk ends. When the receiver stalls, the
// result is held and the next element is not launched until it is taken.
// Reset clears the size registers to 8 and empties the queue and pipeline;
// the operand stores keep no reset and must be written before use.

module matrix_multiply_engine_top import mme_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CMD_W-1:0]          command,
	input  logic [IDX_W-1:0]          row,
	input  logic [IDX_W-1:0]          col,
	input  logic signed [ELEM_W-1:0]  elem_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [IDX_W-1:0]          out_row,
	output logic [IDX_W-1:0]          out_col,
	output logic signed [VALUE_W-1:0] out_value,
	output logic                      last
);

	logic [DIM_W-1:0] rows_of_a_q;
	logic [DIM_W-1:0] shared_dim_q;
	logic [DIM_W-1:0] cols_of_b_q;
	logic             reg_write;
	mme_dims_t        dims;
	mme_item_t        in_item;
	logic             q_valid;
	mme_item_t        q_item;
	logic             q_pop;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_of_a_q  <= DIM_RESET;
			shared_dim_q <= DIM_RESET;
			cols_of_b_q  <= DIM_RESET;
		end else if (reg_write) begin
			case (paddr[3:2])
				REG_ROWS_OF_A:  rows_of_a_q  <= pwdata[DIM_W-1:0];
				REG_SHARED_DIM: shared_dim_q <= pwdata[DIM_W-1:0];
				REG_COLS_OF_B:  cols_of_b_q  <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ROWS_OF_A:  prdata = PDATA_W'(rows_of_a_q);
			REG_SHARED_DIM: prdata = PDATA_W'(shared_dim_q);
			REG_COLS_OF_B:  prdata = PDATA_W'(cols_of_b_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		dims.m = clamp_dim(rows_of_a_q, MAX_DIM);
		dims.n = clamp_dim(shared_dim_q, MAX_DIM);
		dims.p = clamp_dim(cols_of_b_q, MAX_DIM);
	end

	always_comb begin
		in_item.cmd   = command;
		in_item.row   = row;
		in_item.col   = col;
		in_item.value = elem_value;
	end

	mme_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item (in_item),
		.dims    (dims),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	mme_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.dims     (dims),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.out_row  (out_row),
		.out_col  (out_col),
		.out_value(out_value),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

endmodule

### tb/tb_matrix_multiply_engine_top.sv
// Self-checking testbench for matrix_multiply_engine_top: loads A and B, starts
// products and compares every element of C against an in-bench model of the
// multiply. Depends on mme_pkg and the engine's RTL only.

module tb_matrix_multiply_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mme_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int STORE_SIZE    = DEF_MAX_DIM * DEF_MAX_DIM;
	localparam int SETTLE_CYCLES = DEF_MAX_DIM + 12;
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_WORDS  = 140;

	typedef struct {
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} product_elem_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [PDATA_W-1:0]        pwdata;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_ready;
	logic [CMD_W-1:0]          command;
	logic [IDX_W-1:0]          row;
	logic [IDX_W-1:0]          col;
	logic signed [ELEM_W-1:0]  elem_value;
	logic                      out_valid;
	logic                      out_ready;
	logic [IDX_W-1:0]          out_row;
	logic [IDX_W-1:0]          out_col;
	logic signed [VALUE_W-1:0] out_value;
	logic                      last;

	logic [DIM_W-1:0]         dim_reg [3];
	logic signed [ELEM_W-1:0] a_elem [STORE_SIZE];
	logic signed [ELEM_W-1:0] b_elem [STORE_SIZE];
	bit                       a_loaded [STORE_SIZE];
	bit                       b_loaded [STORE_SIZE];
	product_elem_t            product_due [$];
	product_elem_t            head;
	int                       mismatches;
	int                       useful_words;
	int                       burst_left;
	bit                       gaps_on;
	int                       idle_cycles;
	rx_mode_t                 rx_mode;
	int                       rx_left;
	int                       rx_tick;

	matrix_multiply_engine_top #(
		.MAX_DIM(DEF_MAX_DIM)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.row       (row),
		.col       (col),
		.elem_value(elem_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int eff_dim(logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > DEF_MAX_DIM) begin
			return DEF_MAX_DIM;
		end
		return int'(v);
	endfunction

	function automatic int rows_m();
		return eff_dim(dim_reg[REG_ROWS_OF_A]);
	endfunction

	function automatic int inner_n();
		return eff_dim(dim_reg[REG_SHARED_DIM]);
	endfunction

	function automatic int cols_p();
		return eff_dim(dim_reg[REG_COLS_OF_B]);
	endfunction

	function automatic logic signed [ELEM_W-1:0] random_elem();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return -16'sd1;
			3: return 16'sd0;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	function automatic void predict_product();
		product_elem_t e;
		longint        acc;
		for (int i = 0; i < rows_m(); i++) begin
			for (int j = 0; j < cols_p(); j++) begin
				acc = 0;
				for (int k = 0; k < inner_n(); k++) begin
					acc += longint'(a_elem[i * DEF_MAX_DIM + k]) *
						longint'(b_elem[k * DEF_MAX_DIM + j]);
				end
				e.row   = IDX_W'(i);
				e.col   = IDX_W'(j);
				e.value = VALUE_W'(acc);
				e.last  = (i == rows_m() - 1) && (j == cols_p() - 1);
				product_due.push_back(e);
			end
		end
	endfunction

	function automatic void apply_word(logic [CMD_W-1:0] cmd, int r, int c,
			logic signed [ELEM_W-1:0] v);
		case (cmd)
			CMD_LOAD_A: begin
				if (r < rows_m() && c < inner_n()) begin
					a_elem[r * DEF_MAX_DIM + c]   = v;
					a_loaded[r * DEF_MAX_DIM + c] = 1'b1;
					useful_words++;
				end
			end
			CMD_LOAD_B: begin
				if (r < inner_n() && c < cols_p()) begin
					b_elem[r * DEF_MAX_DIM + c]   = v;
					b_loaded[r * DEF_MAX_DIM + c] = 1'b1;
					useful_words++;
				end
			end
			CMD_START: begin
				predict_product();
				useful_words++;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (product_due.size() == 0) begin
				report_mismatch("unexpected word", longint'(out_value), 0);
			end else begin
				head = product_due.pop_front();
				if (out_row !== head.row)
					report_mismatch("out_row", out_row, head.row);
				if (out_col !== head.col)
					report_mismatch("out_col", out_col, head.col);
				if (out_value !== head.value)
					report_mismatch("out_value", longint'(out_value), longint'(head.value));
				if (last !== head.last)
					report_mismatch("last", last, head.last);
			end
		end
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			default:   out_ready <= (rx_tick % 7) < 3;
		endcase
	end

	initial begin : watchdog
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready) ||
					(psel && penable)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_word(logic [CMD_W-1:0] cmd, int r, int c,
			logic signed [ELEM_W-1:0] v);
		if (gaps_on && burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end else if (burst_left > 0) begin
			burst_left--;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		command    <= cmd;
		row        <= IDX_W'(r);
		col        <= IDX_W'(c);
		elem_value <= v;
		do @(posedge clk); while (!in_ready);
		apply_word(cmd, r, c, v);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (product_due.size() > 0) @(posedge clk);
	endtask

	// Loads are written into the stores in the cycle they leave the queue, and the
	// block is given time to finish them before its sizes change.
	task automatic settle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dim(logic [1:0] idx, logic [DIM_W-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		dim_reg[idx] = v;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_dims(logic [DIM_W-1:0] mv, logic [DIM_W-1:0] nv,
			logic [DIM_W-1:0] pv);
		settle();
		write_dim(REG_ROWS_OF_A, mv);
		write_dim(REG_SHARED_DIM, nv);
		write_dim(REG_COLS_OF_B, pv);
	endtask

	task automatic load_missing();
		for (int r = 0; r < rows_m(); r++)
			for (int c = 0; c < inner_n(); c++)
				if (!a_loaded[r * DEF_MAX_DIM + c])
					send_word(CMD_LOAD_A, r, c, random_elem());
		for (int r = 0; r < inner_n(); r++)
			for (int c = 0; c < cols_p(); c++)
				if (!b_loaded[r * DEF_MAX_DIM + c])
					send_word(CMD_LOAD_B, r, c, random_elem());
	endtask

	task automatic test_size_extremes();
		send_word(CMD_LOAD_A, 7, 7, 16'sh7fff);
		send_word(CMD_LOAD_B, 7, 7, 16'sh8000);
		write_dims(4'd0, 4'd1, 4'd15);
		send_word(CMD_LOAD_A, 0, 0, 16'sh8000);
		send_word(CMD_LOAD_B, 0, 0, 16'sh8000);
		send_word(CMD_LOAD_B, 0, 1, 16'sh7fff);
		send_word(CMD_LOAD_B, 0, 2, 16'sd0);
		send_word(CMD_LOAD_B, 0, 3, 16'sd1);
		send_word(CMD_LOAD_B, 0, 4, -16'sd1);
		send_word(CMD_LOAD_B, 0, 5, 16'sh5555);
		send_word(CMD_LOAD_B, 0, 6, 16'shaaaa);
		send_word(CMD_LOAD_B, 0, 7, 16'sd256);
		send_word(CMD_START, 0, 0, 16'sd0);
	endtask

	task automatic test_ignored_words();
		write_dims(4'd2, 4'd2, 4'd1);
		send_word(CMD_LOAD_A, 0, 0, 16'sd256);
		send_word(CMD_LOAD_A, 0, 1, -16'sd256);
		send_word(CMD_LOAD_A, 1, 0, 16'sh7fff);
		send_word(CMD_LOAD_A, 1, 1, -16'sd1);
		send_word(CMD_LOAD_B, 0, 0, 16'sh8000);
		send_word(CMD_LOAD_B, 1, 0, 16'sh7fff);
		send_word(CMD_START, 0, 0, 16'sd0);
		write_dims(4'd1, 4'd1, 4'd1);
		send_word(CMD_LOAD_A, 1, 0, 16'sd111);
		send_word(CMD_LOAD_A, 0, 1, 16'sd5);
		send_word(CMD_LOAD_B, 1, 0, 16'sd7);
		send_word(CMD_LOAD_B, 0, 1, 16'sd9);
		send_word(CMD_UNUSED, 7, 7, -16'sd1);
		send_word(CMD_START, 0, 0, 16'sd0);
		write_dims(4'd2, 4'd2, 4'd1);
		send_word(CMD_START, 0, 0, 16'sd0);
	endtask

	task automatic test_full_shapes();
		write_dims(4'd1, 4'd8, 4'd1);
		for (int k = 0; k < DEF_MAX_DIM; k++) begin
			send_word(CMD_LOAD_A, 0, k, 16'sh8000);
			send_word(CMD_LOAD_B, k, 0, 16'sh8000);
		end
		send_word(CMD_START, 0, 0, 16'sd0);
		hold_until_drained();
		for (int k = 0; k < DEF_MAX_DIM; k++) begin
			send_word(CMD_LOAD_A, 0, k, 16'sh7fff);
		end
		send_word(CMD_START, 0, 0, 16'sd0);
		write_dims(4'd8, 4'd1, 4'd8);
		load_missing();
		send_word(CMD_START, 0, 0, 16'sd0);
	endtask

	task automatic test_random_phases();
		int start_count;
		int loads;
		int pick;
		logic [DIM_W-1:0] nd [3];
		logic [CMD_W-1:0] odd_cmd;
		start_count = useful_words;
		while (useful_words - start_count < RANDOM_WORDS) begin
			if ($urandom_range(0, 3) != 0) begin
				for (int d = 0; d < 3; d++) begin
					pick = $urandom_range(0, 19);
					if (pick == 0)
						nd[d] = 4'd0;
					else if (pick == 1)
						nd[d] = DIM_W'($urandom_range(9, 15));
					else if (pick <= 4)
						nd[d] = DIM_W'($urandom_range(5, 8));
					else
						nd[d] = DIM_W'($urandom_range(1, 4));
				end
				write_dims(nd[0], nd[1], nd[2]);
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			loads = $urandom_range(0, rows_m() * inner_n() + inner_n() * cols_p());
			repeat (loads) begin
				pick = $urandom_range(0, 7);
				if (pick == 0) begin
					// A start here could read elements that were never loaded.
					odd_cmd = CMD_W'($urandom_range(0, 3));
					if (odd_cmd == CMD_START)
						odd_cmd = CMD_UNUSED;
					send_word(odd_cmd, $urandom_range(0, 7), $urandom_range(0, 7),
						random_elem());
				end else if (pick < 4)
					send_word(CMD_LOAD_A, $urandom_range(0, rows_m() - 1),
						$urandom_range(0, inner_n() - 1), random_elem());
				else
					send_word(CMD_LOAD_B, $urandom_range(0, inner_n() - 1),
						$urandom_range(0, cols_p() - 1), random_elem());
			end
			load_missing();
			send_word(CMD_START, $urandom_range(0, 7), $urandom_range(0, 7), random_elem());
			if ($urandom_range(0, 3) == 0)
				send_word(CMD_START, 0, 0, 16'sd0);
			if ($urandom_range(0, 2) == 0)
				hold_until_drained();
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		command    <= CMD_UNUSED;
		row        <= '0;
		col        <= '0;
		elem_value <= '0;
		mismatches  = 0;
		useful_words = 0;
		burst_left  = 0;
		gaps_on     = 1'b0;
		for (int d = 0; d < 3; d++) dim_reg[d] = DIM_RESET;
		for (int e = 0; e < STORE_SIZE; e++) begin
			a_elem[e]   = '0;
			b_elem[e]   = '0;
			a_loaded[e] = 1'b0;
			b_loaded[e] = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_size_extremes();
		gaps_on = 1'b1;
		test_ignored_words();
		test_full_shapes();
		test_random_phases();
		settle();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
